// ----- hdl/tmpf_pkg.sv -----
package tmpf_pkg;

	localparam int DEPTH_DEF = 10;
	localparam int DATA_W = 16;
	localparam int APB_ADDR_W = 3;

	localparam logic [DATA_W-1:0] MIN_VALID_RST = 16'd100;
	localparam logic [DATA_W-1:0] MAX_VALID_RST = 16'd2000;

	// register index, taken from paddr[2]
	localparam logic REG_MIN_VALID = 1'b0;
	localparam logic REG_MAX_VALID = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_ACCUM,
		ST_DIV_GO,
		ST_DIVIDE,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic clear;
		logic insert;
	} store_ctl_t;

endpackage

// ----- hdl/trimmed_mean_pulse_filter.sv -----
// Channel   Dir  Transaction when        Payload
// s_*       in   s_tvalid & s_tready     tdata = pulse_width, tuser = clear
// m_*       out  m_tvalid & m_tready     tdata = average, tuser = updated
// apb       in   psel&penable&pwrite     min_valid at 0x0, max_valid at 0x4
//
// An in-range sample is inserted into the sorted store, then each middle entry
// passes in turn through the shared accumulator, and the iterative divider runs
// its 16 steps before the result register loads; a rejected sample skips the
// accumulator and the divider, and a mean with no middle entry skips only the
// divider.
// Reset empties the store and clears the held average; limits return to 100/2000.
// s_tready is high only while the sequencer is idle; the result register lets the
// next sample in while a result still waits, and the sequencer stalls at its end
// until that register is free.
module trimmed_mean_pulse_filter #(
	parameter int DEPTH = tmpf_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [15:0]                         s_tdata,   // [15:0] pulse_width
	input  logic                                s_tuser,   // [0] clear
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [15:0]                         m_tdata,   // [15:0] average
	output logic                                m_tuser,   // [0] updated
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tmpf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int DW = tmpf_pkg::DATA_W;
	localparam int CW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH+1);
	localparam int SW = DW + CW;

	tmpf_pkg::seq_state_t state_q, state_d;
	tmpf_pkg::store_ctl_t store_ctl;

	logic [DW-1:0] min_valid;
	logic [DW-1:0] max_valid;
	logic [DW-1:0] sample_q;
	logic          in_range_q;
	logic [CW-1:0] idx_q;
	logic [SW-1:0] sum_q;
	logic [DW-1:0] held_avg_q;
	logic          upd_q;
	logic          out_valid_q;
	logic [DW-1:0] out_avg_q;
	logic          out_upd_q;
	logic [DW-1:0] rd_data;
	logic [FW-1:0] fill;
	logic [CW-1:0] mid_cnt;
	logic          div_start;
	logic          div_done;
	logic [DW-1:0] quotient;
	logic          in_xfer;
	logic          accum_en;
	logic          accum_last;
	logic          out_load;

	tmpf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.min_valid (min_valid),
		.max_valid (max_valid)
	);

	tmpf_store #(.DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (store_ctl),
		.sample  (sample_q),
		.rd_idx  (idx_q),
		.rd_data (rd_data),
		.fill    (fill)
	);

	tmpf_div #(.DEPTH(DEPTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (mid_cnt),
		.done     (div_done),
		.quotient (quotient)
	);

	assign in_xfer    = s_tvalid && s_tready;
	assign accum_last = (idx_q == CW'(DEPTH-2));

	// count of filled entries among positions 1 to DEPTH-2
	always_comb begin
		if (fill < FW'(2)) begin
			mid_cnt = '0;
		end else if (fill >= FW'(DEPTH-1)) begin
			mid_cnt = CW'(DEPTH-2);
		end else begin
			mid_cnt = CW'(fill - FW'(1));
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tmpf_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = tmpf_pkg::ST_INSERT;
				end
			end
			tmpf_pkg::ST_INSERT: begin
				state_d = in_range_q ? tmpf_pkg::ST_ACCUM : tmpf_pkg::ST_DONE;
			end
			tmpf_pkg::ST_ACCUM: begin
				if (accum_last) begin
					state_d = (mid_cnt != '0) ? tmpf_pkg::ST_DIV_GO : tmpf_pkg::ST_DONE;
				end
			end
			tmpf_pkg::ST_DIV_GO: begin
				state_d = tmpf_pkg::ST_DIVIDE;
			end
			tmpf_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_d = tmpf_pkg::ST_DONE;
				end
			end
			tmpf_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = tmpf_pkg::ST_IDLE;
				end
			end
			default: state_d = tmpf_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready         = 1'b0;
		store_ctl.clear  = 1'b0;
		store_ctl.insert = 1'b0;
		accum_en         = 1'b0;
		div_start        = 1'b0;
		out_load         = 1'b0;
		unique case (state_q)
			tmpf_pkg::ST_IDLE: begin
				s_tready        = 1'b1;
				store_ctl.clear = in_xfer && s_tuser;
			end
			tmpf_pkg::ST_INSERT: store_ctl.insert = in_range_q;
			tmpf_pkg::ST_ACCUM:  accum_en = 1'b1;
			tmpf_pkg::ST_DIV_GO: div_start = 1'b1;
			tmpf_pkg::ST_DIVIDE: ;
			tmpf_pkg::ST_DONE:   out_load = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// latch the sample and its range check on the input transaction
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q   <= s_tdata;
			in_range_q <= (s_tdata > min_valid) && (s_tdata < max_valid);
		end
	end

	// walk the middle entries and accumulate the filled ones
	always_ff @(posedge clk) begin
		if (store_ctl.insert) begin
			idx_q <= CW'(1);
			sum_q <= '0;
		end else if (accum_en) begin
			if (FW'(idx_q) < fill) begin
				sum_q <= sum_q + SW'(rd_data);
			end
			if (!accum_last) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// hold the mean; flag a recompute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_avg_q <= '0;
			upd_q      <= 1'b0;
		end else begin
			if (in_xfer) begin
				upd_q <= 1'b0;
			end else if (div_done) begin
				held_avg_q <= quotient;
				upd_q      <= 1'b1;
			end
		end
	end

	// result register toward the output channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_avg_q <= held_avg_q;
			out_upd_q <= upd_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_avg_q;
	assign m_tuser  = out_upd_q;

endmodule

// ----- hdl/tmpf_cfg.sv -----
module tmpf_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [tmpf_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	output logic [tmpf_pkg::DATA_W-1:0]          min_valid,
	output logic [tmpf_pkg::DATA_W-1:0]          max_valid
);

	logic [tmpf_pkg::DATA_W-1:0] min_valid_q;
	logic [tmpf_pkg::DATA_W-1:0] max_valid_q;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// write limits on the access phase of a write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_valid_q <= tmpf_pkg::MIN_VALID_RST;
			max_valid_q <= tmpf_pkg::MAX_VALID_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				tmpf_pkg::REG_MIN_VALID: min_valid_q <= pwdata[tmpf_pkg::DATA_W-1:0];
				tmpf_pkg::REG_MAX_VALID: max_valid_q <= pwdata[tmpf_pkg::DATA_W-1:0];
				default: ;
			endcase
		end
	end

	// read back the addressed limit
	always_comb begin
		unique case (paddr[2])
			tmpf_pkg::REG_MIN_VALID: prdata = {16'd0, min_valid_q};
			tmpf_pkg::REG_MAX_VALID: prdata = {16'd0, max_valid_q};
			default: prdata = 32'd0;
		endcase
	end

	assign min_valid = min_valid_q;
	assign max_valid = max_valid_q;

endmodule

// ----- hdl/tmpf_store.sv -----
module tmpf_store #(
	parameter int DEPTH = tmpf_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tmpf_pkg::store_ctl_t               ctl,
	input  logic [tmpf_pkg::DATA_W-1:0]        sample,
	input  logic [$clog2(DEPTH)-1:0]           rd_idx,
	output logic [tmpf_pkg::DATA_W-1:0]        rd_data,
	output logic [$clog2(DEPTH+1)-1:0]         fill
);

	localparam int FW = $clog2(DEPTH+1);

	logic [tmpf_pkg::DATA_W-1:0] entries_q [DEPTH];
	logic [tmpf_pkg::DATA_W-1:0] entries_d [DEPTH];
	logic [FW-1:0]               fill_q;
	logic [DEPTH-1:0]            gt;
	logic                        full;
	logic                        drop_low;

	// mark filled entries smaller than the sample; sorted order makes this a prefix
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			gt[k] = (FW'(k) < fill_q) && (sample > entries_q[k]);
		end
	end

	assign full     = (fill_q == FW'(DEPTH));
	assign drop_low = full && gt[DEPTH-1];

	// next value of each entry: shift up past the insert point, or shift down
	// when the sample exceeds everything in a full store
	for (genvar k = 0; k < DEPTH; k++) begin : g_entry
		if (k == 0) begin : g_first
			always_comb begin
				if (drop_low) begin
					entries_d[k] = entries_q[k+1];
				end else if (gt[k]) begin
					entries_d[k] = entries_q[k];
				end else begin
					entries_d[k] = sample;
				end
			end
		end else if (k == DEPTH-1) begin : g_last
			always_comb begin
				if (drop_low) begin
					entries_d[k] = sample;
				end else if (gt[k]) begin
					entries_d[k] = entries_q[k];
				end else if (gt[k-1]) begin
					entries_d[k] = sample;
				end else begin
					entries_d[k] = entries_q[k-1];
				end
			end
		end else begin : g_mid
			always_comb begin
				if (drop_low) begin
					entries_d[k] = entries_q[k+1];
				end else if (gt[k]) begin
					entries_d[k] = entries_q[k];
				end else if (gt[k-1]) begin
					entries_d[k] = sample;
				end else begin
					entries_d[k] = entries_q[k-1];
				end
			end
		end
	end

	// hold entries unless a sample goes in
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			for (int k = 0; k < DEPTH; k++) begin
				entries_q[k] <= entries_d[k];
			end
		end
	end

	// track how many entries are filled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.clear) begin
			fill_q <= '0;
		end else if (ctl.insert && !full) begin
			fill_q <= fill_q + FW'(1);
		end
	end

	assign rd_data = entries_q[rd_idx];
	assign fill    = fill_q;

endmodule

// ----- hdl/tmpf_div.sv -----
module tmpf_div #(
	parameter int DEPTH = tmpf_pkg::DEPTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic [tmpf_pkg::DATA_W+$clog2(DEPTH)-1:0]  dividend,
	input  logic [$clog2(DEPTH)-1:0]                   divisor,
	output logic                                       done,
	output logic [tmpf_pkg::DATA_W-1:0]                quotient
);

	localparam int CW = $clog2(DEPTH);
	localparam int QW = tmpf_pkg::DATA_W;
	localparam int NW = $clog2(QW+1);

	logic [CW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [CW:0]   trial;
	logic [CW:0]   diff;
	logic          qbit;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, quo_q[QW-1]};
	assign diff  = trial - {1'b0, divisor};
	assign qbit  = (trial >= {1'b0, divisor});

	// the mean never exceeds 16 bits, so the upper dividend bits preload the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[QW+CW-1:QW];
			quo_q <= dividend[QW-1:0];
		end else if (busy_q) begin
			rem_q <= qbit ? diff[CW-1:0] : trial[CW-1:0];
			quo_q <= {quo_q[QW-2:0], qbit};
		end
	end

	// count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + NW'(1);
				if (cnt_q == NW'(QW-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- dv/trimmed_mean_checker.sv -----
`timescale 1ns / 100ps

module trimmed_mean_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [15:0]                     s_tdata,   // [15:0] pulse_width
	input  logic                            s_tuser,   // [0] clear
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [15:0]                     m_tdata,   // [15:0] average
	input  logic                            m_tuser,   // [0] updated
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tmpf_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	input  logic                            pready,
	output int                              pending,
	output int                              err_count
);

	import tmpf_pkg::*;

	localparam int NSLOT = DEPTH_DEF;

	typedef struct packed {
		logic [15:0] average;
		logic        updated;
	} filt_result_t;

	// shadow of the filter state and limits
	logic [15:0]  slot [NSLOT];
	int           n_filled;
	logic [15:0]  mean_hold;
	logic [15:0]  lim_lo;
	logic [15:0]  lim_hi;
	filt_result_t mean_q [$];

	// Place one accepted width into the ascending store, dropping an extreme when full.
	function automatic void sort_in(input logic [15:0] pw);
		int pos;
		int top;
		pos = 0;
		while (pos < n_filled && pw > slot[pos])
			pos++;
		if (pos < n_filled) begin
			top = (n_filled < NSLOT) ? n_filled : NSLOT - 1;
			for (int k = top; k > pos; k--)
				slot[k] = slot[k-1];
			slot[pos] = pw;
			if (n_filled < NSLOT)
				n_filled++;
		end else if (n_filled < NSLOT) begin
			slot[n_filled] = pw;
			n_filled++;
		end else begin
			// larger than every entry of a full store: drop the smallest
			for (int k = 0; k < NSLOT - 1; k++)
				slot[k] = slot[k+1];
			slot[NSLOT-1] = pw;
		end
	endfunction

	// Work out the result of one pulse and advance the shadow state.
	function automatic filt_result_t trimmed_mean(input logic [15:0] pw, input logic clr);
		filt_result_t res;
		logic [31:0]  sum;
		int           cnt;
		res.updated = 1'b0;
		if (clr)
			n_filled = 0;
		if (pw > lim_lo && pw < lim_hi) begin
			sort_in(pw);
			sum = '0;
			cnt = 0;
			for (int k = 1; k < NSLOT - 1; k++) begin
				if (k < n_filled) begin
					sum += 32'(slot[k]);
					cnt++;
				end
			end
			// hold the mean when no middle entry is filled
			if (cnt != 0) begin
				mean_hold   = 16'(sum / 32'(cnt));
				res.updated = 1'b1;
			end
		end
		res.average = mean_hold;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filt_result_t want;
		int           errs;
		if (!arst_n) begin
			for (int k = 0; k < NSLOT; k++)
				slot[k] = '0;
			n_filled  = 0;
			mean_hold = '0;
			lim_lo    = MIN_VALID_RST;
			lim_hi    = MAX_VALID_RST;
			mean_q.delete();
			pending   <= 0;
			err_count <= 0;
		end else begin
			errs = err_count;

			// track register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_MIN_VALID)
					lim_lo = pwdata[15:0];
				else if (paddr[2] == REG_MAX_VALID)
					lim_hi = pwdata[15:0];
			end

			// compare each result transaction with the oldest expectation
			if (m_tvalid && m_tready) begin
				if (mean_q.size() == 0) begin
					$display("%0t: unexpected result average=%0d updated=%0b",
						$time, m_tdata, m_tuser);
					errs++;
				end else begin
					want = mean_q.pop_front();
					if (m_tdata !== want.average) begin
						$display("%0t: average mismatch, expected %0d, actual %0d",
							$time, want.average, m_tdata);
						errs++;
					end
					if (m_tuser !== want.updated) begin
						$display("%0t: updated mismatch, expected %0b, actual %0b",
							$time, want.updated, m_tuser);
						errs++;
					end
				end
			end

			// predict each accepted pulse transaction
			if (s_tvalid && s_tready)
				mean_q.push_back(trimmed_mean(s_tdata, s_tuser));

			pending   <= mean_q.size();
			err_count <= errs;
		end
	end

endmodule

// ----- dv/trimmed_mean_pulse_filter_tb.sv -----
`timescale 1ns / 100ps

module trimmed_mean_pulse_filter_tb;

	import tmpf_pkg::*;

	localparam logic [APB_ADDR_W-1:0] ADDR_MIN = {REG_MIN_VALID, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_MAX = {REG_MAX_VALID, 2'b00};
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;   // [15:0] pulse_width
	logic                  s_tuser;   // [0] clear
	logic                  m_tvalid;
	logic                  m_tready;
	logic [15:0]           m_tdata;   // [15:0] average
	logic                  m_tuser;   // [0] updated
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	int pending;
	int err_count;
	int cycle_cnt = 0;
	bit tx_burst = 1'b0;

	// result-side stall state
	int stall_left;
	int rx_count;
	bit rx_burst;

	always #5 clk = ~clk;

	trimmed_mean_pulse_filter i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	trimmed_mean_checker i_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.pending  (pending),
		.err_count(err_count)
	);

	// Stall the result side for a random count after each transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
			rx_count   <= 0;
			rx_burst   <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (m_tvalid && m_tready) begin
			int n;
			n = rx_burst ? 0 : $urandom_range(0, 8);
			m_tready <= (n == 0);
			stall_left <= (n == 0) ? 0 : n - 1;
			rx_count <= rx_count + 1;
			if (rx_count % 50 == 49)
				rx_burst <= ($urandom_range(0, 2) == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Bound the run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Write one limit register: setup, then access until pready.
	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one pulse after a random gap and hold it until accepted.
	task automatic send_pulse(input logic [15:0] pw, input logic clr);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pw;
		s_tuser  <= clr;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly in-window widths, with window edges and wild values mixed in.
	function automatic logic [15:0] pick_width(input int lo, input int hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8 || hi <= lo + 1)
			return 16'($urandom_range(0, 65535));
		if (r < 14) begin
			case ($urandom_range(0, 3))
				0: return 16'(lo);
				1: return 16'(hi);
				2: return 16'(lo + 1);
				default: return 16'(hi - 1);
			endcase
		end
		return 16'($urandom_range(lo + 1, hi - 1));
	endfunction

	task automatic random_pulses(input int lo, input int hi, input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				tx_burst = ($urandom_range(0, 2) == 0);
			send_pulse(pick_width(lo, hi), ($urandom_range(0, 39) == 0));
		end
	endtask

	// Set new limits while idle, then stream random pulses.
	task automatic run_phase(input int lo, input int hi, input int n);
		drain();
		write_reg(ADDR_MIN, 16'(lo));
		write_reg(ADDR_MAX, 16'(hi));
		random_pulses(lo, hi, n);
	endtask

	initial begin
		int lo;
		int hi;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset limits 100..2000
		send_pulse(16'd500, 1'b1);     // lone sample, no middle entry
		send_pulse(16'd100, 1'b0);     // at lower limit
		send_pulse(16'd2000, 1'b0);    // at upper limit
		send_pulse(16'd0, 1'b0);
		send_pulse(16'd65535, 1'b0);
		send_pulse(16'd101, 1'b0);
		send_pulse(16'd1999, 1'b0);
		send_pulse(16'd600, 1'b1);     // clear, then lone sample again
		send_pulse(16'd1100, 1'b0);
		send_pulse(16'd200, 1'b0);
		send_pulse(16'd900, 1'b0);
		send_pulse(16'd300, 1'b0);
		send_pulse(16'd800, 1'b0);
		send_pulse(16'd400, 1'b0);
		send_pulse(16'd700, 1'b0);
		send_pulse(16'd500, 1'b0);
		send_pulse(16'd1000, 1'b0);    // store now full
		send_pulse(16'd1900, 1'b0);    // above all: drop smallest
		send_pulse(16'd150, 1'b0);     // below some: drop largest
		send_pulse(16'd700, 1'b0);     // equal to an entry
		send_pulse(16'd1899, 1'b0);
		send_pulse(16'd102, 1'b0);
		send_pulse(16'd50, 1'b1);      // clear with a rejected sample
		send_pulse(16'd1000, 1'b0);    // lone sample keeps held mean
		random_pulses(100, 2000, 150);

		// sweep limit settings, extremes first
		run_phase(0, 65535, 220);
		run_phase(65535, 0, 30);
		run_phase(1500, 1500, 30);
		run_phase(0, 2, 60);
		run_phase(65533, 65535, 60);
		run_phase(1000, 1012, 150);
		repeat (4) begin
			lo = $urandom_range(0, 40000);
			hi = lo + $urandom_range(2, 25000);
			run_phase(lo, hi, 150);
		end
		run_phase(100, 2000, 100);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- trimmed_mean_pulse_filter.f -----
hdl/tmpf_pkg.sv
hdl/tmpf_cfg.sv
hdl/tmpf_store.sv
hdl/tmpf_div.sv
hdl/trimmed_mean_pulse_filter.sv
dv/trimmed_mean_checker.sv
dv/trimmed_mean_pulse_filter_tb.sv
